FILE: rtl/core/pgc_pkg.sv
// Shared widths, structs and constant tables of the proxemic Gaussian cell cost core.
// No dependencies; every other file of the core but pgc_checker refers to it by scoped names.
package pgc_pkg;

    // field and datapath widths
    localparam int CoordW  = 24;
    localparam int DiffW   = 25;
    localparam int RotW    = 28;
    localparam int AngW    = 16;
    localparam int HeadW   = 16;
    localparam int VelW    = 16;
    localparam int SqSumW  = 33;
    localparam int SpeedW  = 16;
    localparam int VarW    = 27;
    localparam int ScW     = 26;
    localparam int MagW    = 25;
    localparam int SqW     = 2 * MagW;
    localparam int NumW    = SqW + 2;
    localparam int FqW     = 11;
    localparam int RemW    = VarW + FqW;
    localparam int ExpW    = 17;
    localparam int ArW     = 17;
    localparam int RelW    = 9;
    localparam int CostW   = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 8;

    // algorithm constants
    localparam int CordicSteps = 14;
    localparam int SqrtSteps   = 16;
    localparam int StepsPerStg = 4;
    localparam int RotStages   = 4;
    localparam int DivStages   = 3;
    localparam int ScaleGain   = 39797;
    localparam int VarPerSpeed = 2000;
    localparam int VarFloor    = 500000;
    localparam int RoundHalf   = 32768;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgEnable    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgAmplitude = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCutoff    = 2'd2;

    localparam logic [CostW-1:0] CostUnknown = 8'd255;

    typedef struct packed {
        logic             enable;
        logic [CostW-1:0] amplitude;
        logic [CostW-1:0] cutoff;
    } cfg_t;

    // rotation / speed stage result
    typedef struct packed {
        logic signed [RotW-1:0]  x;
        logic signed [RotW-1:0]  y;
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic [SpeedW-1:0]       speed;
        logic [RelW-1:0]         rel;
        logic [CostW-1:0]        old;
    } rot_t;

    // exponent stage result
    typedef struct packed {
        logic [FqW-1:0]   fq;
        logic             sat;
        logic [RelW-1:0]  rel;
        logic [CostW-1:0] old;
    } quo_t;

    function automatic logic [AngW-1:0] cordic_atan(input int idx);
        logic [AngW-1:0] r;
        case (idx)
            0:       r = 16'd8192;
            1:       r = 16'd4836;
            2:       r = 16'd2555;
            3:       r = 16'd1297;
            4:       r = 16'd651;
            5:       r = 16'd326;
            6:       r = 16'd163;
            7:       r = 16'd81;
            8:       r = 16'd41;
            9:       r = 16'd20;
            10:      r = 16'd10;
            11:      r = 16'd5;
            12:      r = 16'd3;
            13:      r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // exp(-n), Q16
    function automatic logic [ExpW-1:0] exp_int_tab(input logic [2:0] n);
        logic [ExpW-1:0] r;
        case (n)
            3'd0:    r = 17'd65536;
            3'd1:    r = 17'd24109;
            3'd2:    r = 17'd8869;
            3'd3:    r = 17'd3263;
            3'd4:    r = 17'd1200;
            3'd5:    r = 17'd442;
            3'd6:    r = 17'd162;
            3'd7:    r = 17'd60;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // exp(-h/16), Q16
    function automatic logic [ExpW-1:0] exp_hi_tab(input logic [3:0] h);
        logic [ExpW-1:0] r;
        case (h)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            4'd15:   r = 17'd25664;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // exp(-l/256), Q16
    function automatic logic [ExpW-1:0] exp_lo_tab(input logic [3:0] l);
        logic [ExpW-1:0] r;
        case (l)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd65280;
            4'd2:    r = 17'd65026;
            4'd3:    r = 17'd64772;
            4'd4:    r = 17'd64520;
            4'd5:    r = 17'd64268;
            4'd6:    r = 17'd64018;
            4'd7:    r = 17'd63768;
            4'd8:    r = 17'd63520;
            4'd9:    r = 17'd63272;
            4'd10:   r = 17'd63025;
            4'd11:   r = 17'd62780;
            4'd12:   r = 17'd62535;
            4'd13:   r = 17'd62291;
            4'd14:   r = 17'd62048;
            4'd15:   r = 17'd61806;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/pgc_rot.sv
// Input stage, CORDIC rotation into the person frame and speed square root.
// Depends on pgc_pkg.
module pgc_rot (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_vld,
    input  logic signed [pgc_pkg::CoordW-1:0]  cell_x,
    input  logic signed [pgc_pkg::CoordW-1:0]  cell_y,
    input  logic signed [pgc_pkg::CoordW-1:0]  person_x,
    input  logic signed [pgc_pkg::CoordW-1:0]  person_y,
    input  logic        [pgc_pkg::HeadW-1:0]   heading,
    input  logic signed [pgc_pkg::VelW-1:0]    velocity_x,
    input  logic signed [pgc_pkg::VelW-1:0]    velocity_y,
    input  logic        [pgc_pkg::RelW-1:0]    reliability,
    input  logic        [pgc_pkg::CostW-1:0]   prior_cost,
    output logic                               out_vld,
    output pgc_pkg::rot_t                      out_data
);

    localparam int NS = pgc_pkg::RotStages + 1;

    logic                                vld_reg [0:NS-1];
    logic signed [pgc_pkg::RotW-1:0]     x_reg   [0:NS-1];
    logic signed [pgc_pkg::RotW-1:0]     y_reg   [0:NS-1];
    logic signed [pgc_pkg::AngW-1:0]     z_reg   [0:NS-1];
    logic        [pgc_pkg::SqSumW-1:0]   v_reg   [0:NS-1];
    logic        [pgc_pkg::SqSumW-1:0]   r_reg   [0:NS-1];
    logic signed [pgc_pkg::DiffW-1:0]    dx_reg  [0:NS-1];
    logic signed [pgc_pkg::DiffW-1:0]    dy_reg  [0:NS-1];
    logic        [pgc_pkg::RelW-1:0]     rel_reg [0:NS-1];
    logic        [pgc_pkg::CostW-1:0]    old_reg [0:NS-1];

    logic signed [pgc_pkg::DiffW-1:0]    dx_next, dy_next;
    logic signed [pgc_pkg::RotW-1:0]     x_next, y_next, xe, ye;
    logic signed [pgc_pkg::AngW-1:0]     z_next;
    logic        [1:0]                   quad;
    logic signed [2*pgc_pkg::VelW-1:0]   vxx, vyy;
    logic        [pgc_pkg::SqSumW-1:0]   v_next;

    // offsets, quarter turns and squared speed
    always_comb
    begin
        dx_next = pgc_pkg::DiffW'(cell_x) - pgc_pkg::DiffW'(person_x);
        dy_next = pgc_pkg::DiffW'(cell_y) - pgc_pkg::DiffW'(person_y);
        xe      = pgc_pkg::RotW'(dx_next);
        ye      = pgc_pkg::RotW'(dy_next);
        // remainder above an eighth turn folds into the next quadrant
        quad    = heading[15:14] + {1'b0, heading[13]};
        z_next  = {{2{heading[13]}}, heading[13:0]};
        case (quad)
            2'd0:
            begin
                x_next = xe;
                y_next = ye;
            end
            2'd1:
            begin
                x_next = ye;
                y_next = -xe;
            end
            2'd2:
            begin
                x_next = -xe;
                y_next = -ye;
            end
            2'd3:
            begin
                x_next = -ye;
                y_next = xe;
            end
            default:
            begin
                x_next = xe;
                y_next = ye;
            end
        endcase
        vxx    = velocity_x * velocity_x;
        vyy    = velocity_y * velocity_y;
        v_next = {1'b0, vxx} + {1'b0, vyy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < NS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]   <= x_next;
            y_reg[0]   <= y_next;
            z_reg[0]   <= z_next;
            v_reg[0]   <= v_next;
            r_reg[0]   <= '0;
            dx_reg[0]  <= dx_next;
            dy_reg[0]  <= dy_next;
            rel_reg[0] <= reliability;
            old_reg[0] <= prior_cost;
            for (int s = 1; s < NS; s++)
            begin
                dx_reg[s]  <= dx_reg[s-1];
                dy_reg[s]  <= dy_reg[s-1];
                rel_reg[s] <= rel_reg[s-1];
                old_reg[s] <= old_reg[s-1];
            end
        end
    end

    // four root digits and up to four CORDIC steps per stage (fourteen CORDIC steps in all)
    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        localparam int Base = (s - 1) * pgc_pkg::StepsPerStg;

        logic signed [pgc_pkg::RotW-1:0]   xs_next, ys_next;
        logic signed [pgc_pkg::AngW-1:0]   zs_next;
        logic        [pgc_pkg::SqSumW-1:0] vs_next, rs_next;

        always_comb
        begin
            logic signed [pgc_pkg::RotW-1:0]   xa, ya, xsh, ysh;
            logic signed [pgc_pkg::AngW-1:0]   za;
            logic        [pgc_pkg::SqSumW-1:0] va, ra, bt;
            xa = x_reg[s-1];
            ya = y_reg[s-1];
            za = z_reg[s-1];
            va = v_reg[s-1];
            ra = r_reg[s-1];
            for (int k = Base; k < Base + pgc_pkg::StepsPerStg; k++)
            begin
                if (k < pgc_pkg::CordicSteps)
                begin
                    xsh = xa >>> k;
                    ysh = ya >>> k;
                    if (za >= 0)
                    begin
                        xa = xa + ysh;
                        ya = ya - xsh;
                        za = za - signed'(pgc_pkg::cordic_atan(k));
                    end
                    else
                    begin
                        xa = xa - ysh;
                        ya = ya + xsh;
                        za = za + signed'(pgc_pkg::cordic_atan(k));
                    end
                end
                // restoring square root digit
                bt = pgc_pkg::SqSumW'(1) << (2 * (pgc_pkg::SqrtSteps - 1 - k));
                if (va >= ra + bt)
                begin
                    va = va - (ra + bt);
                    ra = (ra >> 1) + bt;
                end
                else
                begin
                    ra = ra >> 1;
                end
            end
            xs_next = xa;
            ys_next = ya;
            zs_next = za;
            vs_next = va;
            rs_next = ra;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[s] <= xs_next;
                y_reg[s] <= ys_next;
                z_reg[s] <= zs_next;
                v_reg[s] <= vs_next;
                r_reg[s] <= rs_next;
            end
        end
    end

    assign out_vld        = vld_reg[NS-1];
    assign out_data.x     = x_reg[NS-1];
    assign out_data.y     = y_reg[NS-1];
    assign out_data.dx    = dx_reg[NS-1];
    assign out_data.dy    = dy_reg[NS-1];
    assign out_data.speed = r_reg[NS-1][pgc_pkg::SpeedW-1:0];
    assign out_data.rel   = rel_reg[NS-1];
    assign out_data.old   = old_reg[NS-1];

    // residual angle and root remainder of the last stage are not needed
    logic unused_tail;
    assign unused_tail = ^{z_reg[NS-1], v_reg[NS-1], r_reg[NS-1][pgc_pkg::SqSumW-1:pgc_pkg::SpeedW]};

endmodule

FILE: rtl/core/pgc_div.sv
// Variance, scaled offsets, squared distance and the Q3.8 exponent by restoring division.
// Depends on pgc_pkg.
module pgc_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_vld,
    input  pgc_pkg::rot_t in_data,
    output logic          out_vld,
    output pgc_pkg::quo_t out_data
);

    localparam int ND = pgc_pkg::DivStages + 1;

    // stage A: variance and gain correction
    logic                              a_vld_reg;
    logic        [pgc_pkg::VarW-1:0]   a_var_reg;
    logic signed [pgc_pkg::ScW-1:0]    a_mx_reg, a_my_reg;
    logic signed [pgc_pkg::DiffW-1:0]  a_dx_reg, a_dy_reg;
    logic        [pgc_pkg::RelW-1:0]   a_rel_reg;
    logic        [pgc_pkg::CostW-1:0]  a_old_reg;

    logic        [pgc_pkg::VarW-1:0]   spd_var, a_var_next;
    logic signed [pgc_pkg::RotW+16:0]  px, py;

    always_comb
    begin
        spd_var    = pgc_pkg::VarW'(in_data.speed) * pgc_pkg::VarW'(pgc_pkg::VarPerSpeed);
        a_var_next = (spd_var < pgc_pkg::VarW'(pgc_pkg::VarFloor)) ?
                     pgc_pkg::VarW'(pgc_pkg::VarFloor) : spd_var;
        px = in_data.x * $signed({1'b0, 16'(pgc_pkg::ScaleGain)});
        py = in_data.y * $signed({1'b0, 16'(pgc_pkg::ScaleGain)});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_var_reg <= a_var_next;
            a_mx_reg  <= px[pgc_pkg::ScW+15:16];
            a_my_reg  <= py[pgc_pkg::ScW+15:16];
            a_dx_reg  <= in_data.dx;
            a_dy_reg  <= in_data.dy;
            a_rel_reg <= in_data.rel;
            a_old_reg <= in_data.old;
        end
    end

    // stage B: pick front or rear operands, square them
    logic                              b_vld_reg, b_front_reg;
    logic        [pgc_pkg::SqW-1:0]    b_sa_reg, b_sb_reg;
    logic        [pgc_pkg::VarW-1:0]   b_var_reg;
    logic        [pgc_pkg::RelW-1:0]   b_rel_reg;
    logic        [pgc_pkg::CostW-1:0]  b_old_reg;

    logic                              front;
    logic signed [pgc_pkg::ScW-1:0]    sa_s, sb_s;
    logic        [pgc_pkg::ScW-1:0]    sa_abs, sb_abs;

    always_comb
    begin
        front  = (a_mx_reg > 0);
        sa_s   = front ? a_mx_reg : pgc_pkg::ScW'(a_dx_reg);
        sb_s   = front ? a_my_reg : pgc_pkg::ScW'(a_dy_reg);
        sa_abs = sa_s[pgc_pkg::ScW-1] ? -sa_s : sa_s;
        sb_abs = sb_s[pgc_pkg::ScW-1] ? -sb_s : sb_s;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_front_reg <= front;
            b_sa_reg    <= pgc_pkg::SqW'(sa_abs[pgc_pkg::MagW-1:0]) *
                           pgc_pkg::SqW'(sa_abs[pgc_pkg::MagW-1:0]);
            b_sb_reg    <= pgc_pkg::SqW'(sb_abs[pgc_pkg::MagW-1:0]) *
                           pgc_pkg::SqW'(sb_abs[pgc_pkg::MagW-1:0]);
            b_var_reg   <= a_var_reg;
            b_rel_reg   <= a_rel_reg;
            b_old_reg   <= a_old_reg;
        end
    end

    // stage C (division slot 0): numerator, range check
    logic                              vld_reg [0:ND-1];
    logic                              sat_reg [0:ND-1];
    logic        [pgc_pkg::RemW-1:0]   rem_reg [0:ND-1];
    logic        [pgc_pkg::FqW-1:0]    q_reg   [0:ND-1];
    logic        [pgc_pkg::VarW-1:0]   var_reg [0:ND-1];
    logic        [pgc_pkg::RelW-1:0]   rel_reg [0:ND-1];
    logic        [pgc_pkg::CostW-1:0]  old_reg [0:ND-1];

    logic        [pgc_pkg::NumW-1:0]   num;
    logic        [pgc_pkg::NumW+5:0]   num64;
    logic                              sat_next;

    always_comb
    begin
        num = (b_front_reg ? (pgc_pkg::NumW'(b_sa_reg) << 1) : (pgc_pkg::NumW'(b_sa_reg) << 2))
              + pgc_pkg::NumW'(b_sb_reg) * pgc_pkg::NumW'(3);
        num64    = {num, 6'b0};
        // exponent of 8.0 or more gives a zero exponential
        sat_next = (num64 >= ((pgc_pkg::NumW+6)'(b_var_reg) << pgc_pkg::FqW));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_reg[0] <= sat_next;
            rem_reg[0] <= sat_next ? '0 : num64[pgc_pkg::RemW-1:0];
            q_reg[0]   <= '0;
            var_reg[0] <= b_var_reg;
            rel_reg[0] <= b_rel_reg;
            old_reg[0] <= b_old_reg;
            for (int d = 1; d < ND; d++)
            begin
                sat_reg[d] <= sat_reg[d-1];
                var_reg[d] <= var_reg[d-1];
                rel_reg[d] <= rel_reg[d-1];
                old_reg[d] <= old_reg[d-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            for (int d = 0; d < ND; d++)
            begin
                vld_reg[d] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg  <= in_vld;
            b_vld_reg  <= a_vld_reg;
            vld_reg[0] <= b_vld_reg;
            for (int d = 1; d < ND; d++)
            begin
                vld_reg[d] <= vld_reg[d-1];
            end
        end
    end

    // quotient bits, up to four per stage (eleven in all), most significant first
    for (genvar d = 1; d < ND; d++)
    begin : g_div
        localparam int Hi = pgc_pkg::FqW - 1 - (d - 1) * pgc_pkg::StepsPerStg;

        logic [pgc_pkg::RemW-1:0] rem_next;
        logic [pgc_pkg::FqW-1:0]  q_next;

        always_comb
        begin
            logic [pgc_pkg::RemW-1:0] ra, dv;
            ra     = rem_reg[d-1];
            q_next = q_reg[d-1];
            dv     = '0;
            for (int k = Hi; k > Hi - pgc_pkg::StepsPerStg; k--)
            begin
                if (k >= 0)
                begin
                    dv = pgc_pkg::RemW'(var_reg[d-1]) << k;
                    if (ra >= dv)
                    begin
                        ra        = ra - dv;
                        q_next[k] = 1'b1;
                    end
                end
            end
            rem_next = ra;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[d] <= rem_next;
                q_reg[d]   <= q_next;
            end
        end
    end

    assign out_vld      = vld_reg[ND-1];
    assign out_data.fq  = q_reg[ND-1];
    assign out_data.sat = sat_reg[ND-1];
    assign out_data.rel = rel_reg[ND-1];
    assign out_data.old = old_reg[ND-1];

    // remainder and the bits of the gain products outside the kept window are not needed
    logic unused_rem;
    assign unused_rem = ^{rem_reg[ND-1], px[pgc_pkg::RotW+16:pgc_pkg::ScW+16], px[15:0],
                          py[pgc_pkg::RotW+16:pgc_pkg::ScW+16], py[15:0]};

endmodule

FILE: rtl/core/pgc_exp.sv
// Table exponential, amplitude and reliability scaling, cutoff test and output register.
// Depends on pgc_pkg.
module pgc_exp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  pgc_pkg::quo_t               in_data,
    input  pgc_pkg::cfg_t               cfg,
    output logic                        out_vld,
    output logic [pgc_pkg::CostW-1:0]   out_cost,
    output logic                        out_write
);

    localparam int PW = 2 * pgc_pkg::ExpW;

    logic                         g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg;
    logic [pgc_pkg::ExpW-1:0]     g_e1_reg, h_e_reg;
    logic [pgc_pkg::ArW-1:0]      g_ar_reg, h_ar_reg;
    logic [3:0]                   g_lo_reg;
    logic                         g_sat_reg;
    logic [pgc_pkg::CostW-1:0]    g_old_reg, h_old_reg, i_old_reg;
    logic [pgc_pkg::CostW-1:0]    i_val_reg;
    logic [pgc_pkg::CostW-1:0]    j_cost_reg;
    logic                         j_write_reg;

    logic [PW-1:0] p1, p2, p3;
    logic [9:0]    val_wide;
    logic [pgc_pkg::CostW-1:0] val_sat;
    logic          wr;

    always_comb
    begin
        p1 = PW'(pgc_pkg::exp_int_tab(in_data.fq[10:8])) *
             PW'(pgc_pkg::exp_hi_tab(in_data.fq[7:4])) + PW'(pgc_pkg::RoundHalf);
        p2 = PW'(g_e1_reg) * PW'(pgc_pkg::exp_lo_tab(g_lo_reg)) + PW'(pgc_pkg::RoundHalf);
        p3 = PW'(h_ar_reg) * PW'(h_e_reg);
        val_wide = p3[PW-1:24];
        val_sat  = (val_wide > 10'd255) ? 8'd255 : val_wide[pgc_pkg::CostW-1:0];
        wr = cfg.enable && (cfg.cutoff < cfg.amplitude) && (i_old_reg != pgc_pkg::CostUnknown)
             && (i_val_reg >= cfg.cutoff);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // integer and high fraction product
            g_e1_reg  <= p1[pgc_pkg::ExpW+15:16];
            g_lo_reg  <= in_data.fq[3:0];
            g_sat_reg <= in_data.sat;
            g_ar_reg  <= pgc_pkg::ArW'(cfg.amplitude) * pgc_pkg::ArW'(in_data.rel);
            g_old_reg <= in_data.old;
            // low fraction product, zero beyond range
            h_e_reg   <= g_sat_reg ? '0 : p2[pgc_pkg::ExpW+15:16];
            h_ar_reg  <= g_ar_reg;
            h_old_reg <= g_old_reg;
            // scaled cost
            i_val_reg <= val_sat;
            i_old_reg <= h_old_reg;
            // merge with the old cost
            j_write_reg <= wr;
            j_cost_reg  <= (wr && (i_val_reg > i_old_reg)) ? i_val_reg : i_old_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_vld_reg <= in_vld;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
        end
    end

    assign out_vld   = j_vld_reg;
    assign out_cost  = j_cost_reg;
    assign out_write = j_write_reg;

    logic unused_p;
    assign unused_p = ^{p1[PW-1:pgc_pkg::ExpW+16], p1[15:0], p2[PW-1:pgc_pkg::ExpW+16],
                        p2[15:0], p3[23:0]};

endmodule

FILE: rtl/core/proxemic_gaussian_cell_cost_core.sv
// An input transfer passes through the pgc_rot, pgc_div and pgc_exp registers to the output register.
// Throughput: one cell per cycle; the whole pipeline holds while a result waits
// on out_stall, so in_stall follows out_valid && out_stall.
// Reset: asynchronous rst_n clears all valid bits; enable=1, amplitude=77, cutoff=10.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Depends on pgc_pkg, pgc_rot, pgc_div, pgc_exp.
module proxemic_gaussian_cell_cost_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pgc_pkg::CoordW-1:0]  cell_x,
    input  logic signed [pgc_pkg::CoordW-1:0]  cell_y,
    input  logic signed [pgc_pkg::CoordW-1:0]  person_x,
    input  logic signed [pgc_pkg::CoordW-1:0]  person_y,
    input  logic        [pgc_pkg::HeadW-1:0]   heading,
    input  logic signed [pgc_pkg::VelW-1:0]    velocity_x,
    input  logic signed [pgc_pkg::VelW-1:0]    velocity_y,
    input  logic        [pgc_pkg::RelW-1:0]    reliability,
    input  logic        [pgc_pkg::CostW-1:0]   prior_cost,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [pgc_pkg::CostW-1:0]   new_cost,
    output logic                               write,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [pgc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic        [pgc_pkg::CfgDatW-1:0] cfg_data
);

    pgc_pkg::cfg_t cfg_reg;
    logic          adv;
    logic          rot_vld, div_vld;
    pgc_pkg::rot_t rot_data;
    pgc_pkg::quo_t div_data;

    // global pipeline advance
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable    <= 1'b1;
            cfg_reg.amplitude <= 8'd77;
            cfg_reg.cutoff    <= 8'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pgc_pkg::CfgEnable:    cfg_reg.enable    <= cfg_data[0];
                pgc_pkg::CfgAmplitude: cfg_reg.amplitude <= cfg_data;
                pgc_pkg::CfgCutoff:    cfg_reg.cutoff    <= cfg_data;
                default:               cfg_reg           <= cfg_reg;
            endcase
        end
    end

    pgc_rot u_rot (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_vld      (in_valid),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .person_x    (person_x),
        .person_y    (person_y),
        .heading     (heading),
        .velocity_x  (velocity_x),
        .velocity_y  (velocity_y),
        .reliability (reliability),
        .prior_cost  (prior_cost),
        .out_vld     (rot_vld),
        .out_data    (rot_data)
    );

    pgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (rot_vld),
        .in_data  (rot_data),
        .out_vld  (div_vld),
        .out_data (div_data)
    );

    pgc_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (div_vld),
        .in_data   (div_data),
        .cfg       (cfg_reg),
        .out_vld   (out_valid),
        .out_cost  (new_cost),
        .out_write (write)
    );

endmodule

FILE: rtl/core/pgc_checker.sv
// Port-level checks of the proxemic Gaussian cell cost core, bound to the top level.
// Depends on proxemic_gaussian_cell_cost_core port names only.
module pgc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] new_cost,
    input logic       write,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_cost) && $stable(write))
        else $error("stalled result changed");

    // input back-pressure only while a result is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // the pipeline keeps moving when the output is free
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // register writes are never refused
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind proxemic_gaussian_cell_cost_core pgc_checker u_pgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_cost  (new_cost),
    .write     (write),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
